// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/eiupe_pkg.sv -----
// Shared types and constants of the Ethernet/IPv4/UDP payload extractor.
// No dependencies; imported by every module of the block.
package eiupe_pkg;

    localparam logic [15:0] MAX_FRAME_LEN = 16'd65535;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4  = 4'd4;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [15:0] UDP_HDR_LEN   = 16'd8;

    // Header offsets in the frame.
    localparam logic [4:0] IP_START_ETH    = 5'd14;
    localparam logic [4:0] IP_START_COOKED = 5'd16;
    localparam logic [15:0] POS_TYPE_HI    = 16'd12;
    localparam logic [15:0] POS_TYPE_LO    = 16'd13;
    localparam logic [15:0] POS_COOKED_HI  = 16'd14;
    localparam logic [15:0] POS_COOKED_LO  = 16'd15;

    // Verdict codes.
    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_NOT_IP    = 3'd1;
    localparam logic [2:0] VERDICT_NOT_V4    = 3'd2;
    localparam logic [2:0] VERDICT_NOT_UDP   = 3'd3;
    localparam logic [2:0] VERDICT_LEN_MISS  = 3'd4;
    localparam logic [2:0] VERDICT_MALFORMED = 3'd5;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Output queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
        logic [2:0]  verdict;
    } t_out_item;

    // Up to two results from one input transfer, payload first.
    typedef struct packed {
        logic      push_payload;
        logic      push_verdict;
        t_out_item payload_item;
        t_out_item verdict_item;
    } t_push;

endpackage

// ----- hdl/eiupe_parser.sv -----
// Per-byte header parser: frame state registers and result generation.
// Depends on eiupe_pkg.
module eiupe_parser import eiupe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic        i_cfg_write,
    input  logic [15:0] i_cfg_data,
    output t_push       o_push
);

    logic [15:0] r_target_len;
    logic [15:0] r_pos,    n_pos;
    logic        r_cooked, n_cooked;
    logic [3:0]  r_ihl,    n_ihl;
    logic [15:0] r_ulen,   n_ulen;
    logic [15:0] r_port,   n_port;
    logic [7:0]  r_hold,   n_hold;
    logic [2:0]  r_drop,   n_drop;

    always_comb begin
        logic [7:0]  b;
        logic [15:0] pair;
        logic [4:0]  s;
        logic [17:0] p_x;
        logic [17:0] u_x;
        logic [17:0] plen_x;
        logic [15:0] plen;
        logic [2:0]  code;

        b        = i_item.frame_byte;
        n_pos    = r_pos;
        n_cooked = r_cooked;
        n_ihl    = r_ihl;
        n_ulen   = r_ulen;
        n_port   = r_port;
        n_hold   = r_hold;
        n_drop   = r_drop;
        o_push   = '0;
        p_x      = {2'b00, r_pos};
        s        = IP_START_ETH;
        u_x      = '0;
        plen     = '0;
        plen_x   = '0;
        pair     = '0;
        code     = VERDICT_OK;

        if (r_pos >= MAX_FRAME_LEN) begin
            if (n_drop == VERDICT_OK) begin
                n_drop = VERDICT_MALFORMED;
            end
        end else begin
            if (r_pos == POS_TYPE_HI) begin
                n_hold = b;
            end
            pair = {n_hold, b};
            if (r_pos == POS_TYPE_LO && pair != ETHERTYPE_IPV4) begin
                n_cooked = 1'b1;
            end
            if (n_cooked && r_pos == POS_COOKED_HI) begin
                n_hold = b;
            end
            pair = {n_hold, b};
            if (n_cooked && r_pos == POS_COOKED_LO && n_drop == VERDICT_OK &&
                pair != ETHERTYPE_IPV4) begin
                n_drop = VERDICT_NOT_IP;
            end

            s = n_cooked ? IP_START_COOKED : IP_START_ETH;
            if (p_x == 18'(s) && n_drop == VERDICT_OK) begin
                if (b[7:4] != IP_VERSION_4) begin
                    n_drop = VERDICT_NOT_V4;
                end else begin
                    n_ihl = b[3:0];
                    if (n_ihl < IHL_MIN) begin
                        n_drop = VERDICT_MALFORMED;
                    end
                end
            end
            if (p_x == 18'(s) + 18'd9 && n_drop == VERDICT_OK && b != IP_PROTO_UDP) begin
                n_drop = VERDICT_NOT_UDP;
            end

            // UDP header start: IP start plus IHL words.
            u_x = 18'(s) + {12'd0, n_ihl, 2'b00};
            if (n_drop == VERDICT_OK) begin
                if (p_x == u_x + 18'd2 || p_x == u_x + 18'd4) begin
                    n_hold = b;
                end
                pair = {n_hold, b};
                if (p_x == u_x + 18'd3) begin
                    n_port = pair;
                end
                if (p_x == u_x + 18'd5) begin
                    n_ulen = pair;
                    if (n_ulen < UDP_HDR_LEN) begin
                        n_drop = VERDICT_MALFORMED;
                    end else if (r_target_len != '0 &&
                                 r_target_len != n_ulen - UDP_HDR_LEN) begin
                        n_drop = VERDICT_LEN_MISS;
                    end
                end
            end

            plen   = (n_ulen >= UDP_HDR_LEN) ? n_ulen - UDP_HDR_LEN : '0;
            plen_x = {2'b00, plen};
            if (n_drop == VERDICT_OK && n_ulen >= UDP_HDR_LEN && p_x >= u_x + 18'd8 &&
                p_x < u_x + 18'd8 + plen_x) begin
                o_push.push_payload                = 1'b1;
                o_push.payload_item.result_kind    = KIND_PAYLOAD;
                o_push.payload_item.payload_byte   = b;
                o_push.payload_item.payload_last   = (p_x == u_x + 18'd7 + plen_x);
            end
            n_pos = r_pos + 16'd1;
        end

        if (i_item.frame_end) begin
            s      = n_cooked ? IP_START_COOKED : IP_START_ETH;
            u_x    = 18'(s) + {12'd0, n_ihl, 2'b00};
            plen   = (n_ulen >= UDP_HDR_LEN) ? n_ulen - UDP_HDR_LEN : '0;
            plen_x = {2'b00, plen};
            code   = n_drop;
            // Frame ended before the headers or payload were complete.
            if (code == VERDICT_OK && !(p_x >= u_x + 18'd7 && p_x >= u_x + 18'd7 + plen_x)) begin
                code = VERDICT_MALFORMED;
            end
            o_push.push_verdict                 = 1'b1;
            o_push.verdict_item.result_kind     = KIND_VERDICT;
            o_push.verdict_item.dest_port       = n_port;
            o_push.verdict_item.payload_length  = plen;
            o_push.verdict_item.verdict         = code;
            n_pos    = '0;
            n_cooked = 1'b0;
            n_ihl    = '0;
            n_ulen   = '0;
            n_port   = '0;
            n_hold   = '0;
            n_drop   = VERDICT_OK;
        end

        // Drop the results of a byte that is not transferred this cycle.
        if (!i_accept) begin
            o_push.push_payload = 1'b0;
            o_push.push_verdict = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_len <= '0;
        end else if (i_cfg_write) begin
            r_target_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_cooked <= 1'b0;
            r_ihl    <= '0;
            r_ulen   <= '0;
            r_port   <= '0;
            r_hold   <= '0;
            r_drop   <= VERDICT_OK;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_cooked <= n_cooked;
            r_ihl    <= n_ihl;
            r_ulen   <= n_ulen;
            r_port   <= n_port;
            r_hold   <= n_hold;
            r_drop   <= n_drop;
        end
    end

endmodule

// ----- hdl/eiupe_out_queue.sv -----
// Small result queue: takes up to two results per cycle, hands out one unless stalled.
// Depends on eiupe_pkg.
module eiupe_out_queue import eiupe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    t_out_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;
    logic               push_any;
    logic               push_both;
    logic               pop;
    t_out_item          first_item;

    assign push_any   = i_push.push_payload | i_push.push_verdict;
    assign push_both  = i_push.push_payload & i_push.push_verdict;
    assign first_item = i_push.push_payload ? i_push.payload_item : i_push.verdict_item;
    assign pop        = o_valid & ~i_stall;

    assign n_wr_ptr = r_wr_ptr + QPTR_W'(push_any) + QPTR_W'(push_both);
    assign n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
    assign n_count  = r_count + QCNT_W'(push_any) + QCNT_W'(push_both) - QCNT_W'(pop);

    // Stall input while a two-result transfer might not fit.
    assign o_full  = r_count > QCNT_W'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_any) begin
            r_mem[r_wr_ptr] <= first_item;
        end
        if (push_both) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.verdict_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hdl/ethernet_ipv4_udp_payload_extractor_core.sv -----
// Results are registered in the result queue before o_out_valid offers them.
// Throughput: one frame byte per cycle; the frame's last byte can give a payload
// byte and the verdict, two output transfers. o_in_stall is high while the
// four-entry result queue holds three or more results, which only output stalls cause.
// Reset (i_rst_n low, synchronous) clears frame state, queue and length filter.
// Depends on eiupe_pkg, eiupe_parser, eiupe_out_queue.
module ethernet_ipv4_udp_payload_extractor_core import eiupe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Frame bytes in
    input  logic        i_in_valid,
    input  t_in_item    i_in,
    output logic        o_in_stall,
    // Payload and verdict results out
    output logic        o_out_valid,
    output t_out_item   o_out,
    input  logic        i_out_stall,
    // Length filter register write
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready
);

    logic  in_accept;
    logic  queue_full;
    t_push push;

    // Config writes are always taken; sending them only while the block is idle is the user's duty, unchecked.
    assign o_cfg_ready = 1'b1;

    // Hold the input side while the queue cannot take a full two-result transfer.
    assign o_in_stall = queue_full;
    assign in_accept  = i_in_valid & ~queue_full;

    // Parse one byte per transfer and decide which results it causes.
    eiupe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in),
        .i_cfg_write (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push)
    );

    // Register results; this queue also decouples input from output stalls.
    eiupe_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_valid (o_out_valid),
        .o_item  (o_out),
        .i_stall (i_out_stall)
    );

endmodule

// ----- hdl/eiupe_checker.sv -----
// Port-level checker for the payload extractor, bound to the top level.
// Depends on eiupe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eiupe_checker import eiupe_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input t_in_item    i_in,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input t_out_item   o_out,
    input logic        i_out_stall,
    input logic        i_cfg_valid,
    input logic [15:0] i_cfg_data,
    input logic        o_cfg_ready
);

    logic out_held;
    logic end_transfer;
    logic payload_out;
    logic payload_fields_zero;

    assign out_held            = o_out_valid && i_out_stall;
    assign end_transfer        = i_in_valid && !o_in_stall && i_in.frame_end;
    assign payload_out         = o_out_valid && o_out.result_kind == KIND_PAYLOAD;
    assign payload_fields_zero = o_out.verdict == VERDICT_OK && o_out.dest_port == '0 &&
                                 o_out.payload_length == '0;

    `ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, out_held, o_out_valid)
    `ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, out_held, $stable(o_out))
    `ASSERT_NEXT(a_verdict_follows_end, i_clk, i_rst_n, end_transfer, o_out_valid)
    `ASSERT_SAME(a_payload_fields_clear, i_clk, i_rst_n, payload_out, payload_fields_zero)

endmodule

bind ethernet_ipv4_udp_payload_extractor_core eiupe_checker u_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ethernet_ipv4_udp_payload_extractor_core.
// Builds Ethernet/cooked IPv4/UDP frames, predicts payload and verdict transfers
// in place, and compares them field by field. Depends on eiupe_pkg and the core.
module tb_top;
    import eiupe_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int END_CYCLES      = 10;
    localparam int BYTES_PER_PHASE = 40;
    localparam int ERROR_REPORTS   = 20;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in        = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_cfg_ready;

    ethernet_ipv4_udp_payload_extractor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // Parser state mirror
    logic [15:0] frame_pos;
    logic        via_cooked;
    logic [3:0]  ihl_words;
    logic [15:0] udp_len_field;
    logic [15:0] dest_port_field;
    logic [7:0]  byte_hold;
    logic [2:0]  first_drop;
    logic [15:0] len_filter;

    t_out_item   expected_results[$];
    logic [7:0]  frame_q[$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int fail_count    = 0;
    int frames_sent   = 0;
    int bytes_sent    = 0;
    int payload_seen  = 0;
    int verdict_seen[8];
    int idle_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_frame_state();
        frame_pos       = '0;
        via_cooked      = 1'b0;
        ihl_words       = '0;
        udp_len_field   = '0;
        dest_port_field = '0;
        byte_hold       = '0;
        first_drop      = VERDICT_OK;
    endfunction

    // Advance the parser mirror by one frame byte; queue the transfers it causes.
    function automatic void predict_byte(input logic [7:0] b, input logic fend);
        int unsigned p, s, u, plen;
        logic [2:0]  code;
        t_out_item   item;
        p = frame_pos;
        if (p >= MAX_FRAME_LEN) begin
            if (first_drop == VERDICT_OK) first_drop = VERDICT_MALFORMED;
        end else begin
            if (p == POS_TYPE_HI) byte_hold = b;
            if (p == POS_TYPE_LO && {byte_hold, b} != ETHERTYPE_IPV4) via_cooked = 1'b1;
            if (via_cooked && p == POS_COOKED_HI) byte_hold = b;
            if (via_cooked && p == POS_COOKED_LO && first_drop == VERDICT_OK &&
                {byte_hold, b} != ETHERTYPE_IPV4)
                first_drop = VERDICT_NOT_IP;
            s = via_cooked ? IP_START_COOKED : IP_START_ETH;
            if (p == s && first_drop == VERDICT_OK) begin
                if (b[7:4] != IP_VERSION_4) begin
                    first_drop = VERDICT_NOT_V4;
                end else begin
                    ihl_words = b[3:0];
                    if (ihl_words < IHL_MIN) first_drop = VERDICT_MALFORMED;
                end
            end
            if (p == s + 9 && first_drop == VERDICT_OK && b != IP_PROTO_UDP)
                first_drop = VERDICT_NOT_UDP;
            u = s + 4 * ihl_words;
            if (first_drop == VERDICT_OK) begin
                if (p == u + 2 || p == u + 4) byte_hold = b;
                if (p == u + 3) dest_port_field = {byte_hold, b};
                if (p == u + 5) begin
                    udp_len_field = {byte_hold, b};
                    if (udp_len_field < UDP_HDR_LEN)
                        first_drop = VERDICT_MALFORMED;
                    else if (len_filter != 0 && len_filter != udp_len_field - UDP_HDR_LEN)
                        first_drop = VERDICT_LEN_MISS;
                end
            end
            plen = (udp_len_field >= UDP_HDR_LEN) ? udp_len_field - UDP_HDR_LEN : 0;
            if (first_drop == VERDICT_OK && udp_len_field >= UDP_HDR_LEN &&
                p >= u + 8 && p < u + 8 + plen) begin
                item              = '0;
                item.result_kind  = KIND_PAYLOAD;
                item.payload_byte = b;
                item.payload_last = (p == u + 7 + plen);
                expected_results.push_back(item);
            end
            frame_pos = 16'(p + 1);
        end
        if (fend) begin
            s    = via_cooked ? IP_START_COOKED : IP_START_ETH;
            u    = s + 4 * ihl_words;
            plen = (udp_len_field >= UDP_HDR_LEN) ? udp_len_field - UDP_HDR_LEN : 0;
            code = first_drop;
            // Frame ended before the headers or the whole payload were seen
            if (code == VERDICT_OK && !(p >= u + 7 && p >= u + 7 + plen))
                code = VERDICT_MALFORMED;
            item                = '0;
            item.result_kind    = KIND_VERDICT;
            item.dest_port      = dest_port_field;
            item.payload_length = 16'(plen);
            item.verdict        = code;
            expected_results.push_back(item);
            clear_frame_state();
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            if (fail_count < ERROR_REPORTS)
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Receiver side: random stall, compare every output transfer.
    always @(posedge i_clk) begin : check_results
        t_out_item exp_item;
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                if (fail_count < ERROR_REPORTS)
                    $error("unexpected result transfer, kind %0d", o_out.result_kind);
                fail_count++;
            end else begin
                exp_item = expected_results.pop_front();
                check_field("result_kind", exp_item.result_kind, o_out.result_kind);
                check_field("payload_byte", exp_item.payload_byte, o_out.payload_byte);
                check_field("payload_last", exp_item.payload_last, o_out.payload_last);
                check_field("dest_port", exp_item.dest_port, o_out.dest_port);
                check_field("payload_length", exp_item.payload_length,
                            o_out.payload_length);
                check_field("verdict", exp_item.verdict, o_out.verdict);
            end
            if (o_out.result_kind == KIND_PAYLOAD) payload_seen++;
            else verdict_seen[o_out.verdict]++;
        end
    end

    // End the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{frame_byte: value, frame_end: last};
        do @(posedge i_clk); while (o_in_stall);
        predict_byte(value, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // frames may still sit in the parser without a pending result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_len_filter(input logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        len_filter = value;
    endtask

    // Assemble a frame: MACs, type (cooked adds a non-IPv4 type first), IP header
    // sized by its IHL (at least five words), UDP header, body and link padding.
    function automatic void build_udp_frame(input bit cooked, input logic [7:0] ver_ihl,
                                            input logic [7:0] proto,
                                            input logic [15:0] port,
                                            input logic [15:0] udp_len,
                                            input int body_len, input int pad_len);
        logic [15:0] link_type;
        int          hdr_len;
        frame_q.delete();
        repeat (12) frame_q.push_back(8'($urandom));
        if (cooked) begin
            do link_type = 16'($urandom); while (link_type == ETHERTYPE_IPV4);
            frame_q.push_back(link_type[15:8]);
            frame_q.push_back(link_type[7:0]);
        end
        frame_q.push_back(ETHERTYPE_IPV4[15:8]);
        frame_q.push_back(ETHERTYPE_IPV4[7:0]);
        frame_q.push_back(ver_ihl);
        hdr_len = (ver_ihl[3:0] < IHL_MIN) ? 20 : 4 * ver_ihl[3:0];
        for (int i = 1; i < hdr_len; i++) frame_q.push_back(i == 9 ? proto : 8'($urandom));
        repeat (2) frame_q.push_back(8'($urandom));
        frame_q.push_back(port[15:8]);
        frame_q.push_back(port[7:0]);
        frame_q.push_back(udp_len[15:8]);
        frame_q.push_back(udp_len[7:0]);
        repeat (2 + body_len + pad_len) frame_q.push_back(8'($urandom));
    endfunction

    // Directed header cases, no idling. Frames whose verdict is settled early
    // are cut short after the deciding byte.
    task automatic test_header_checks();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        build_udp_frame(0, 8'h45, IP_PROTO_UDP, 16'hFFFF, 16'd12, 4, 0); send_frame();
        // cooked capture, one payload byte marked last
        build_udp_frame(1, 8'h45, IP_PROTO_UDP, 16'h0000, 16'd9, 1, 0);  send_frame();
        // largest IHL, empty payload
        build_udp_frame(0, 8'h4F, IP_PROTO_UDP, 16'h1234, 16'd8, 0, 0);  send_frame();
        build_udp_frame(0, 8'h65, IP_PROTO_UDP, 16'h0101, 16'd10, 2, 0);
        frame_q = frame_q[0:14];
        send_frame();
        build_udp_frame(0, 8'h45, 8'd6, 16'h0202, 16'd10, 2, 0);
        frame_q = frame_q[0:23];
        send_frame();
        // short IP header
        build_udp_frame(0, 8'h44, IP_PROTO_UDP, 16'h0303, 16'd10, 2, 0);
        frame_q = frame_q[0:14];
        send_frame();
        // UDP length below the header size
        build_udp_frame(0, 8'h45, IP_PROTO_UDP, 16'h0404, 16'd7, 2, 0);
        frame_q = frame_q[0:39];
        send_frame();
        // truncated inside the payload, then inside the headers
        build_udp_frame(0, 8'h45, IP_PROTO_UDP, 16'h0505, 16'd20, 5, 0); send_frame();
        build_udp_frame(0, 8'h45, IP_PROTO_UDP, 16'h0606, 16'd20, 12, 0);
        frame_q = frame_q[0:19];
        send_frame();
        // link padding after the datagram
        build_udp_frame(0, 8'h45, IP_PROTO_UDP, 16'h0707, 16'd10, 2, 6); send_frame();
        // bad version and bad protocol: the earlier failure is reported
        build_udp_frame(0, 8'h35, 8'd6, 16'h0808, 16'd10, 2, 0);
        frame_q = frame_q[0:23];
        send_frame();
        // neither link type is IPv4
        build_udp_frame(1, 8'h45, IP_PROTO_UDP, 16'h0909, 16'd10, 2, 0);
        frame_q[14] = frame_q[14] ^ 8'h01;
        frame_q = frame_q[0:15];
        send_frame();
        frame_q = '{8'($urandom)};
        send_frame();
    endtask

    // Length filter with a sender that idles most of the time.
    task automatic test_length_filter();
        write_len_filter(16'd3);
        in_idle_pct   = 69;
        out_stall_pct = 0;
        build_udp_frame(0, 8'h45, IP_PROTO_UDP, 16'h1111, 16'd11, 3, 0); send_frame();
        build_udp_frame(1, 8'h45, IP_PROTO_UDP, 16'h2222, 16'd12, 4, 0);
        frame_q = frame_q[0:41];
        send_frame();
        build_udp_frame(0, 8'h45, IP_PROTO_UDP, 16'h3333, 16'd7, 0, 0);
        frame_q = frame_q[0:39];
        send_frame();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [15:0] filter);
        int          phase_bytes, pick, plen, pad, cut_at, flip_type;
        bit          cooked;
        logic [7:0]  ver_ihl, proto;
        logic [15:0] udp_len;
        write_len_filter(filter);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        phase_bytes   = 0;
        while (phase_bytes < BYTES_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick >= 85) begin
                // noise, sometimes with an IPv4 type and a plausible first IP byte
                frame_q.delete();
                repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom));
                if (frame_q.size() > 14 && $urandom_range(1)) begin
                    frame_q[12] = ETHERTYPE_IPV4[15:8];
                    frame_q[13] = ETHERTYPE_IPV4[7:0];
                    frame_q[14] = 8'h45;
                end
            end else begin
                cooked    = ($urandom_range(9) < 3);
                ver_ihl   = {IP_VERSION_4, ($urandom_range(3) == 0) ?
                             4'($urandom_range(6, 15)) : IHL_MIN};
                plen      = ($urandom_range(9) == 0) ? $urandom_range(13, 80)
                                                      : $urandom_range(0, 12);
                if (filter != 0 && $urandom_range(1)) plen = filter;
                proto     = IP_PROTO_UDP;
                udp_len   = 16'(plen + 8);
                pad       = ($urandom_range(4) == 0) ? $urandom_range(1, 6) : 0;
                cut_at    = 0;
                flip_type = 0;
                if (pick >= 60) begin
                    case ($urandom_range(5))
                        0: ver_ihl[7:4] = 4'($urandom_range(5, 19));
                        1: proto = 8'(IP_PROTO_UDP + $urandom_range(1, 255));
                        2: ver_ihl[3:0] = 4'($urandom_range(0, 4));
                        3: udp_len = 16'($urandom_range(0, 7));
                        4: cut_at = 1;
                        default: flip_type = 1;
                    endcase
                end
                build_udp_frame(cooked, ver_ihl, proto, 16'($urandom), udp_len, plen, pad);
                if (cut_at != 0)
                    frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
                if (flip_type != 0)
                    frame_q[cooked ? 14 : 12] ^= 8'($urandom_range(1, 255));
            end
            send_frame();
            phase_bytes += frame_q.size();
        end
    endtask

    initial begin
        len_filter = '0;
        clear_frame_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_checks();
        test_length_filter();
        test_random_traffic(0, 69, 16'd0);
        test_random_traffic(29, 29, 16'($urandom_range(0, 6)));

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Covered %0d frames (%0d bytes): header checks, length filter, random",
                 frames_sent, bytes_sent);
        $display("traffic under four idle/stall mixes; %0d payload bytes, verdicts %0d/%0d/%0d",
                 payload_seen, verdict_seen[0], verdict_seen[1], verdict_seen[2]);
        $display("/%0d/%0d/%0d", verdict_seen[3], verdict_seen[4], verdict_seen[5]);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
